// ===== sv/vrp_pkg.sv =====
// Shared types and constants for the vertex rotate and project block.
// No dependencies; used by vrp_div, vertex_rotate_project and its checker.
package vrp_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_OBJECT_SCALE  = 3'd0;
  localparam logic [2:0] REG_OFFSET_X      = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y      = 3'd2;
  localparam logic [2:0] REG_OFFSET_Z      = 3'd3;
  localparam logic [2:0] REG_EYE_DISTANCE  = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;

  localparam logic [15:0] RST_OBJECT_SCALE  = 16'd2944;
  localparam logic [15:0] RST_OFFSET_Z      = 16'd6400;
  localparam logic [15:0] RST_EYE_DISTANCE  = 16'd2560;
  localparam logic [7:0]  RST_SCREEN_SIZE   = 8'd32;

  // Projection numerator, its magnitude and the divisor (256 * depth).
  localparam int NUM_W = 49;
  localparam int MAG_W = 48;
  localparam int DEN_W = 38;
  // Quotient bits resolved by the divider; larger values saturate anyway.
  localparam int QB    = 9;
  localparam int DIV_LAT = QB + 2;
  localparam int FRONT_LAT = 6;
  localparam int LAT = FRONT_LAT + DIV_LAT;

  typedef struct packed {
    logic signed [7:0] q;
    logic              sat;
  } div_res_t;

endpackage

// ===== sv/vrp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, saturating to 8 bits.
// Depends on vrp_pkg for widths and the result struct.
module vrp_div (
  input  logic                              clk,
  input  logic signed [vrp_pkg::NUM_W-1:0]  num,
  input  logic        [vrp_pkg::DEN_W-1:0]  den,
  output vrp_pkg::div_res_t                 res
);

  localparam int MW = vrp_pkg::MAG_W;
  localparam int QB = vrp_pkg::QB;

  logic [MW-1:0]                rem_r [0:QB-1];
  logic [QB-1:0]                q_r   [0:QB];
  logic [vrp_pkg::DEN_W-1:0]    d_r   [0:QB-1];
  logic                         neg_r [0:QB];
  logic                         ovf_r [0:QB];
  vrp_pkg::div_res_t            res_r;
  vrp_pkg::div_res_t            res_nxt;

  logic [MW-1:0] mag;

  assign mag = MW'(num < 0 ? -num : num);

  always_ff @(posedge clk) begin
    rem_r[0] <= mag;
    q_r[0]   <= '0;
    d_r[0]   <= den;
    neg_r[0] <= (num < 0);
    ovf_r[0] <= (mag >= (MW'(den) << QB));
  end

  // Stage i settles quotient bit QB-i.
  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [MW-1:0] sh;
    logic          ge;
    assign sh = MW'(d_r[i-1]) << (QB - i);
    assign ge = (rem_r[i-1] >= sh);
    always_ff @(posedge clk) begin
      q_r[i]   <= q_r[i-1] | (QB'(ge) << (QB - i));
      neg_r[i] <= neg_r[i-1];
      ovf_r[i] <= ovf_r[i-1];
    end
    if (i < QB) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? rem_r[i-1] - sh : rem_r[i-1];
        d_r[i]   <= d_r[i-1];
      end
    end
  end

  always_comb begin
    res_nxt.sat = 1'b0;
    res_nxt.q   = 8'sd0;
    if (!neg_r[QB]) begin
      if (ovf_r[QB] || q_r[QB] > QB'(127)) begin
        res_nxt.q   = 8'sd127;
        res_nxt.sat = 1'b1;
      end else begin
        res_nxt.q = 8'(q_r[QB]);
      end
    end else begin
      if (ovf_r[QB] || q_r[QB] > QB'(128)) begin
        res_nxt.q   = -8'sd128;
        res_nxt.sat = 1'b1;
      end else begin
        res_nxt.q = 8'(-q_r[QB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== sv/vertex_rotate_project.sv =====
// Top level of the vertex rotate and project pipeline.
// Depends on vrp_pkg and instantiates two vrp_div dividers.
//
// Usage: one vertex item enters at a clock edge where start is high (busy is
// always low, so every start is taken). The item carries Q4.12 coordinates,
// the Q1.14 cosine and sine of two angles and a frame-end mark. The vertex is
// rotated about Y, then Z, then X, scaled and translated by the configuration
// registers and projected onto the screen with a perspective divide.
// Each item yields exactly one result, shown on the out_ ports with out_valid
// high for a single cycle once the item has passed the six arithmetic stages and the dividers.
// Throughput is one item per clock: six arithmetic stages (three rotation
// stages, scaling, projection products, numerator sums) feed two dividers that
// resolve one quotient bit per stage, all fully pipelined.
// The receiver cannot stall; results are never held back.
// Reset (synchronous, active low) empties the pipeline and loads the register
// reset values. Registers are written through cfg_we, cfg_idx and cfg_wdata;
// indexes beyond the list are ignored. Write them only while no
// item is in flight.
module vertex_rotate_project (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_vert_x,
  input  logic signed [15:0] in_vert_y,
  input  logic signed [15:0] in_vert_z,
  input  logic signed [15:0] in_cos_first,
  input  logic signed [15:0] in_sin_first,
  input  logic signed [15:0] in_cos_second,
  input  logic signed [15:0] in_sin_second,
  input  logic               in_frame_end_in,
  output logic               out_valid,
  output logic signed [7:0]  out_screen_x,
  output logic signed [7:0]  out_screen_y,
  output logic               out_clipped,
  output logic               out_behind_eye,
  output logic               out_frame_end_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);

  localparam int NW = vrp_pkg::NUM_W;
  localparam int LAT = vrp_pkg::LAT;
  localparam int BL = vrp_pkg::DIV_LAT + 1;

  // Configuration registers.
  logic [15:0]        scale_r;
  logic signed [15:0] offx_r, offy_r, offz_r;
  logic [15:0]        eye_r;
  logic [7:0]         width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= vrp_pkg::RST_OBJECT_SCALE;
      offx_r   <= '0;
      offy_r   <= '0;
      offz_r   <= vrp_pkg::RST_OFFSET_Z;
      eye_r    <= vrp_pkg::RST_EYE_DISTANCE;
      width_r  <= vrp_pkg::RST_SCREEN_SIZE;
      height_r <= vrp_pkg::RST_SCREEN_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vrp_pkg::REG_OBJECT_SCALE:  scale_r  <= cfg_wdata;
        vrp_pkg::REG_OFFSET_X:      offx_r   <= cfg_wdata;
        vrp_pkg::REG_OFFSET_Y:      offy_r   <= cfg_wdata;
        vrp_pkg::REG_OFFSET_Z:      offz_r   <= cfg_wdata;
        vrp_pkg::REG_EYE_DISTANCE:  eye_r    <= cfg_wdata;
        vrp_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[7:0];
        vrp_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Control: valid and frame-end travel the full depth, the depth flag from
  // the projection stage onward.
  logic [LAT-1:0] vld_r, fe_r;
  logic [BL-1:0]  bh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Stage 1: rotate about Y.
  logic signed [32:0] s1x_nxt, s1z_nxt;
  logic signed [18:0] x1_r, z1_r;
  logic signed [15:0] y1_r, c2a_r, s2a_r;

  assign s1x_nxt = 33'(in_vert_x) * 33'(in_cos_first) - 33'(in_vert_z) * 33'(in_sin_first);
  assign s1z_nxt = 33'(in_vert_x) * 33'(in_sin_first) + 33'(in_vert_z) * 33'(in_cos_first);

  always_ff @(posedge clk) begin
    x1_r  <= 19'(s1x_nxt >>> 14);
    z1_r  <= 19'(s1z_nxt >>> 14);
    y1_r  <= in_vert_y;
    c2a_r <= in_cos_second;
    s2a_r <= in_sin_second;
  end

  // Stage 2: rotate about Z.
  logic signed [35:0] s2x_nxt, s2y_nxt;
  logic signed [21:0] x2_r, y2_r;
  logic signed [18:0] z1b_r;
  logic signed [15:0] c2b_r, s2b_r;

  assign s2x_nxt = 36'(x1_r) * 36'(c2a_r) - 36'(y1_r) * 36'(s2a_r);
  assign s2y_nxt = 36'(x1_r) * 36'(s2a_r) + 36'(y1_r) * 36'(c2a_r);

  always_ff @(posedge clk) begin
    x2_r  <= 22'(s2x_nxt >>> 14);
    y2_r  <= 22'(s2y_nxt >>> 14);
    z1b_r <= z1_r;
    c2b_r <= c2a_r;
    s2b_r <= s2a_r;
  end

  // Stage 3: rotate about X.
  logic signed [38:0] s3y_nxt, s3z_nxt;
  logic signed [24:0] y3_r, z3_r;
  logic signed [21:0] x3_r;

  assign s3y_nxt = 39'(y2_r) * 39'(c2b_r) - 39'(z1b_r) * 39'(s2b_r);
  assign s3z_nxt = 39'(y2_r) * 39'(s2b_r) + 39'(z1b_r) * 39'(c2b_r);

  always_ff @(posedge clk) begin
    y3_r <= 25'(s3y_nxt >>> 14);
    z3_r <= 25'(s3z_nxt >>> 14);
    x3_r <= x2_r;
  end

  // Stage 4: scale and translate (result in Q.8).
  logic signed [16:0] scale_s;
  logic signed [38:0] px_nxt;
  logic signed [41:0] py_nxt, pz_nxt;
  logic signed [27:0] tx_r;
  logic signed [30:0] ty_r, tz_r;

  assign scale_s = $signed({1'b0, scale_r});
  assign px_nxt  = 39'(x3_r) * 39'(scale_s);
  assign py_nxt  = 42'(y3_r) * 42'(scale_s);
  assign pz_nxt  = 42'(z3_r) * 42'(scale_s);

  always_ff @(posedge clk) begin
    tx_r <= 28'(px_nxt >>> 12) + 28'(offx_r);
    ty_r <= 31'(py_nxt >>> 12) + 31'(offy_r);
    tz_r <= 31'(pz_nxt >>> 12) + 31'(offz_r);
  end

  // Stage 5: projection products. The numerator is size*128*Z + E*coord and
  // the divisor 256*Z, which keeps the half-screen offset exact.
  logic signed [15:0] wsh_s, hsh_s;
  logic signed [16:0] eye_s;
  logic signed [NW-1:0] pwx_r, phy_r, pex_r, pey_r;
  logic [vrp_pkg::DEN_W-1:0] den5_r;
  logic beh5_r;

  assign wsh_s = $signed({1'b0, width_r, 7'b0});
  assign hsh_s = $signed({1'b0, height_r, 7'b0});
  assign eye_s = $signed({1'b0, eye_r});

  always_ff @(posedge clk) begin
    pwx_r  <= NW'(wsh_s) * NW'(tz_r);
    phy_r  <= NW'(hsh_s) * NW'(tz_r);
    pex_r  <= NW'(eye_s) * NW'(tx_r);
    pey_r  <= NW'(eye_s) * NW'(ty_r);
    den5_r <= {tz_r[29:0], 8'b0};
    beh5_r <= (tz_r <= 0);
  end

  // Stage 6: numerator sums.
  logic signed [NW-1:0] numx_r, numy_r;
  logic [vrp_pkg::DEN_W-1:0] den6_r;

  always_ff @(posedge clk) begin
    numx_r <= pwx_r + pex_r;
    numy_r <= phy_r + pey_r;
    den6_r <= den5_r;
    fe_r   <= {fe_r[LAT-2:0], in_frame_end_in};
    bh_r   <= {bh_r[BL-2:0], beh5_r};
  end

  vrp_pkg::div_res_t resx, resy;

  vrp_div u_div_x (.clk(clk), .num(numx_r), .den(den6_r), .res(resx));
  vrp_div u_div_y (.clk(clk), .num(numy_r), .den(den6_r), .res(resy));

  // A vertex at or behind the eye reports zero coordinates and no clipping.
  assign out_valid         = vld_r[LAT-1];
  assign out_behind_eye    = bh_r[BL-1];
  assign out_frame_end_out = fe_r[LAT-1];
  assign out_screen_x      = out_behind_eye ? 8'sd0 : resx.q;
  assign out_screen_y      = out_behind_eye ? 8'sd0 : resy.q;
  assign out_clipped       = !out_behind_eye && (resx.sat || resy.sat);

endmodule

// ===== sv/vrp_checker.sv =====
// Port-level checks for vertex_rotate_project, bound to the top level.
// Depends on vrp_pkg for the pipeline latency.
module vrp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic signed [7:0] out_screen_x,
  input logic signed [7:0] out_screen_y,
  input logic              out_clipped,
  input logic              out_behind_eye
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(vrp_pkg::LAT) out_valid)
    else $error("item did not produce a result at the pipeline latency");

  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_behind_eye) |->
      (out_screen_x == 8'sd0 && out_screen_y == 8'sd0 && !out_clipped))
    else $error("vertex behind the eye gave nonzero output");

  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_screen_x == 8'sd127 || out_screen_x == -8'sd128 ||
       out_screen_y == 8'sd127 || out_screen_y == -8'sd128))
    else $error("clipped set without a saturated coordinate");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
  .out_clipped(out_clipped), .out_behind_eye(out_behind_eye)
);
